/* rtl/hpq_pkg.sv */
package hpq_pkg;

  // Heap geometry and entry widths.
  localparam int CAPACITY     = 256;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;

  // Index into the store, occupancy count, and child index (which can reach 2*CAPACITY).
  localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = CNT_W + 1;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_EXT_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DN_FIN,
    S_DONE
  } state_t;

endpackage

/* rtl/hpq_if.sv */
// Input channel: one word is one insert or extract command.
interface hpq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [hpq_pkg::KEY_BITS-1:0]      in_key;
  logic [hpq_pkg::PAYLOAD_BITS-1:0]  in_payload;

  modport source (output valid, cmd, in_key, in_payload, input ready);
  modport sink   (input valid, cmd, in_key, in_payload, output ready);
endinterface

// Result channel: one word per command.
interface hpq_out_if;
  logic                              valid;
  logic                              ready;
  logic [hpq_pkg::KEY_BITS-1:0]      out_key;
  logic [hpq_pkg::PAYLOAD_BITS-1:0]  out_payload;
  logic [1:0]                        status;
  logic [hpq_pkg::CNT_W-1:0]         occupancy;

  modport source (output valid, out_key, out_payload, status, occupancy, input ready);
  modport sink   (input valid, out_key, out_payload, status, occupancy, output ready);
endinterface

/* rtl/binary_min_heap_queue.sv */
// An insert climbs level by level; an extract reads the root and the last entry, then sinks
// level by level. Extract on empty and insert on full only post a status. One word is handled
// at a time, and the next is accepted in the cycle after the result is posted.
// Synchronous active-low reset empties the heap and clears all control state; the entry
// memory is not cleared, since no entry at or beyond the occupancy is ever used.
module binary_min_heap_queue (
  input logic      clk,
  input logic      rst_n,
  hpq_in_if.sink   in_chan,
  hpq_out_if.source out_chan
);
  import hpq_pkg::*;

  // Entry memory with registered read data.
  entry_t             mem [CAPACITY];
  logic [PTR_W-1:0]   rd_addr;
  entry_t             rd_data_r;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  entry_t             wr_data;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   pos_r, pos_nxt;
  entry_t             mov_r, mov_nxt;
  entry_t             left_r, left_nxt;
  logic               lwin_r, lwin_nxt;
  entry_t             res_r, res_nxt;
  status_t            res_stat_r, res_stat_nxt;

  logic               out_valid_r, out_valid_nxt;
  entry_t             out_ent_r, out_ent_nxt;
  status_t            out_stat_r, out_stat_nxt;
  logic [CNT_W-1:0]   out_occ_r, out_occ_nxt;

  // Tree navigation and comparisons shared by both combinational blocks.
  logic               accept;
  logic               out_free;
  logic [PTR_W-1:0]   parent_idx;
  logic [CHILD_W-1:0] lc, rc, nlc;
  logic               lc_ok, rc_ok, nlc_ok;
  logic               pos_top, ins_stop, lwin, rwin, dn_move;
  logic [PTR_W-1:0]   dn_child;
  entry_t             dn_ent;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept     = in_chan.valid && in_chan.ready;
  assign out_free   = !out_valid_r || out_chan.ready;
  assign pos_top    = (pos_r == '0);
  assign parent_idx = PTR_W'((pos_r - PTR_W'(1)) >> 1);
  assign ins_stop   = (rd_data_r.key <= mov_r.key);
  assign lc         = CHILD_W'({pos_r, 1'b0}) + CHILD_W'(1);
  assign rc         = lc + CHILD_W'(1);
  assign lc_ok      = (lc < CHILD_W'(count_r));
  assign rc_ok      = (rc < CHILD_W'(count_r));
  assign lwin       = (rd_data_r.key < mov_r.key);
  assign rwin       = lwin_r ? (rd_data_r.key < left_r.key) : (rd_data_r.key < mov_r.key);

  // Sift-down choice once both children are known; left wins ties.
  always_comb begin
    dn_move  = 1'b0;
    dn_child = lc[PTR_W-1:0];
    dn_ent   = left_r;
    if (rwin) begin
      dn_move  = 1'b1;
      dn_child = rc[PTR_W-1:0];
      dn_ent   = rd_data_r;
    end else if (lwin_r) begin
      dn_move  = 1'b1;
    end
  end

  assign nlc    = CHILD_W'({dn_child, 1'b0}) + CHILD_W'(1);
  assign nlc_ok = (nlc < CHILD_W'(count_r));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.cmd == CMD_INSERT) begin
            state_nxt = (count_r == CNT_W'(CAPACITY)) ? S_DONE : S_INS_RD;
          end else begin
            state_nxt = (count_r == '0) ? S_DONE : S_EXT_ROOT;
          end
        end
      end
      S_INS_RD:   state_nxt = pos_top ? S_DONE : S_INS_CMP;
      S_INS_CMP:  state_nxt = ins_stop ? S_DONE : S_INS_RD;
      S_EXT_ROOT: state_nxt = S_EXT_LAST;
      S_EXT_LAST: state_nxt = S_EXT_LOAD;
      S_EXT_LOAD: state_nxt = lc_ok ? S_DN_RD : S_DONE;
      S_DN_RD: begin
        if (rc_ok)     state_nxt = S_DN_CMP;
        else if (lwin) state_nxt = S_DN_FIN;
        else           state_nxt = S_DONE;
      end
      S_DN_CMP: begin
        if (!dn_move)   state_nxt = S_DONE;
        else if (nlc_ok) state_nxt = S_DN_RD;
        else            state_nxt = S_DN_FIN;
      end
      S_DN_FIN:   state_nxt = S_DONE;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and handshake outputs.
  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    mov_nxt       = mov_r;
    left_nxt      = left_r;
    lwin_nxt      = lwin_r;
    res_nxt       = res_r;
    res_stat_nxt  = res_stat_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = mov_r;
    out_ent_nxt   = out_ent_r;
    out_stat_nxt  = out_stat_r;
    out_occ_nxt   = out_occ_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      S_IDLE: begin
        res_nxt      = '0;
        res_stat_nxt = ST_DONE;
        if (accept) begin
          if (in_chan.cmd == CMD_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              res_stat_nxt = ST_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              pos_nxt   = count_r[PTR_W-1:0];
              mov_nxt   = '{key: in_chan.in_key, payload: in_chan.in_payload};
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = ST_EMPTY;
            end else begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
      end
      // Sift up: the new entry rides in a register while parents move down.
      S_INS_RD: begin
        rd_addr = parent_idx;
        if (pos_top) begin
          wr_en = 1'b1;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (!ins_stop) begin
          wr_data = rd_data_r;
          pos_nxt = parent_idx;
        end
      end
      // The sift down starts at the root, so its child indexes are ready in the load cycle.
      S_EXT_ROOT: begin
        rd_addr = '0;
        pos_nxt = '0;
      end
      S_EXT_LAST: begin
        res_nxt = rd_data_r;
        rd_addr = count_r[PTR_W-1:0];
      end
      S_EXT_LOAD: begin
        mov_nxt = rd_data_r;
        pos_nxt = '0;
        rd_addr = lc[PTR_W-1:0];
        if (!lc_ok) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = rd_data_r;
        end
      end
      // Sift down: left child arrives here, the right one is fetched if present.
      S_DN_RD: begin
        left_nxt = rd_data_r;
        lwin_nxt = lwin;
        rd_addr  = rc[PTR_W-1:0];
        if (!rc_ok) begin
          wr_en = 1'b1;
          if (lwin) begin
            wr_data = rd_data_r;
            pos_nxt = lc[PTR_W-1:0];
          end
        end
      end
      S_DN_CMP: begin
        wr_en   = 1'b1;
        rd_addr = nlc[PTR_W-1:0];
        if (dn_move) begin
          wr_data = dn_ent;
          pos_nxt = dn_child;
        end
      end
      S_DN_FIN: begin
        wr_en = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = res_r;
          out_stat_nxt  = res_stat_r;
          out_occ_nxt   = count_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    mov_r      <= mov_nxt;
    left_r     <= left_nxt;
    lwin_r     <= lwin_nxt;
    res_r      <= res_nxt;
    res_stat_r <= res_stat_nxt;
    out_ent_r  <= out_ent_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_key     = out_ent_r.key;
  assign out_chan.out_payload = out_ent_r.payload;
  assign out_chan.status      = out_stat_r;
  assign out_chan.occupancy   = out_occ_r;

endmodule

/* sim/binary_min_heap_queue_test.sv */
`timescale 1ns / 100ps

module binary_min_heap_queue_test;
  import hpq_pkg::*;

  // One expected result word, laid out like the result channel payload.
  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    status_t                 status;
    logic [CNT_W-1:0]        occupancy;
  } heap_result_t;

  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst_n;

  hpq_in_if  in_chan ();
  hpq_out_if out_chan ();

  binary_min_heap_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the heap, advanced once per accepted command word.
  logic [KEY_BITS-1:0]     shadow_keys     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] shadow_payloads [CAPACITY];
  int unsigned             shadow_count;

  heap_result_t pending_results[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int error_count;
  int words_sent;
  int words_checked;
  int full_hits;
  int empty_hits;
  int peak_occupancy;
  int stall_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void swap_shadow(input int unsigned a, input int unsigned b);
    logic [KEY_BITS-1:0]     k;
    logic [PAYLOAD_BITS-1:0] p;
    k = shadow_keys[a];
    p = shadow_payloads[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_payloads[a] = shadow_payloads[b];
    shadow_keys[b] = k;
    shadow_payloads[b] = p;
  endfunction

  // Apply one command to the shadow heap and return the word the block should send back.
  function automatic heap_result_t predict_heap_op(input cmd_t op,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [PAYLOAD_BITS-1:0] payload);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  left;
    int unsigned  right;
    int unsigned  best;
    bit           settled;
    r = '0;
    r.status = ST_DONE;
    if (op == CMD_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_keys[pos] = key;
        shadow_payloads[pos] = payload;
        shadow_count++;
        // Climb while the parent is strictly larger.
        settled = 1'b0;
        while (pos > 0 && !settled) begin
          parent = (pos - 1) / 2;
          if (shadow_keys[parent] <= shadow_keys[pos]) begin
            settled = 1'b1;
          end else begin
            swap_shadow(parent, pos);
            pos = parent;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = shadow_keys[0];
        r.payload = shadow_payloads[0];
        shadow_count--;
        shadow_keys[0] = shadow_keys[shadow_count];
        shadow_payloads[0] = shadow_payloads[shadow_count];
        // Sink: a child wins only when strictly smaller, the left one first.
        pos = 0;
        settled = 1'b0;
        while (!settled) begin
          left = 2 * pos + 1;
          right = left + 1;
          best = pos;
          if (left < shadow_count && shadow_keys[left] < shadow_keys[best]) best = left;
          if (right < shadow_count && shadow_keys[right] < shadow_keys[best]) best = right;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            swap_shadow(pos, best);
            pos = best;
          end
        end
      end
    end
    r.occupancy = CNT_W'(shadow_count);
    return r;
  endfunction

  // Offer one command word, after a random gap, and record its expected result on acceptance.
  task automatic send_word(input cmd_t op, input logic [KEY_BITS-1:0] key,
                           input logic [PAYLOAD_BITS-1:0] payload);
    heap_result_t expected_word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.cmd        <= op;
    in_chan.in_key     <= key;
    in_chan.in_payload <= payload;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_word = predict_heap_op(op, key, payload);
    pending_results.push_back(expected_word);
    words_sent++;
    if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
  endtask

  function automatic logic [KEY_BITS-1:0] random_key(input int style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(7);
      default: begin
        case ($urandom_range(4))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KEY_BITS-1){1'b0}}};
          3: return {1'b0, {(KEY_BITS-1){1'b1}}};
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Extremes of key and payload, ties that exercise both sift rules, and the empty-heap error case.
  task automatic test_directed_cases();
    send_word(CMD_EXTRACT, '0, '0);
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_INSERT, '0, '0);
    send_word(CMD_INSERT, 32'd7, 16'd1);
    send_word(CMD_INSERT, 32'd7, 16'd2);
    send_word(CMD_INSERT, 32'd7, 16'd3);
    send_word(CMD_INSERT, 32'd3, 16'd4);
    send_word(CMD_INSERT, 32'd7, 16'd5);
    send_word(CMD_INSERT, 32'hAAAA_AAAA, 16'h5555);
    send_word(CMD_INSERT, 32'h5555_5555, 16'hAAAA);
    // Key and payload fields are don't-care on extract.
    send_word(CMD_EXTRACT, '1, '1);
    repeat (8) send_word(CMD_EXTRACT, '0, '0);
    send_word(CMD_EXTRACT, '1, '1);
    send_word(CMD_INSERT, 32'd0, 16'hFFFF);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 16'h0000);
    send_word(CMD_EXTRACT, '0, '0);
    send_word(CMD_EXTRACT, '0, '0);
  endtask

  // Fill to capacity with many ties, hit the full case, then drain past empty.
  task automatic test_fill_and_drain();
    repeat (CAPACITY) send_word(CMD_INSERT, random_key(1 + $urandom_range(1)),
                                 16'($urandom_range(16'hFFFF)));
    send_word(CMD_INSERT, '1, '1);
    send_word(CMD_INSERT, '0, '0);
    repeat (CAPACITY + 1) send_word(CMD_EXTRACT, $urandom(), 16'($urandom_range(16'hFFFF)));
  endtask

  // The receiver holds off for a long stretch while commands keep coming.
  task automatic test_result_backpressure();
    hold_requests++;
    repeat (16) send_word(CMD_INSERT, random_key(0), 16'($urandom_range(16'hFFFF)));
    repeat (12) send_word(CMD_EXTRACT, '0, '0);
  endtask

  // Segments of random commands, each with its own insert bias and key style.
  task automatic test_random_traffic(input int word_total);
    int insert_pct;
    int key_style;
    cmd_t op;
    for (int n = 0; n < word_total; n++) begin
      if (n % 30 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 50;
          default: insert_pct = 20;
        endcase
        key_style = $urandom_range(2);
      end
      op = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
      send_word(op, random_key(key_style), 16'($urandom_range(16'hFFFF)));
    end
  endtask

  // Receiver: random ready, or a long hold-off counted here when one is requested.
  initial begin
    int hold_left;
    int holds_taken;
    hold_left = 0;
    holds_taken = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Each accepted result word is compared with the oldest expectation.
  always @(posedge clk) begin
    heap_result_t expected_word;
    heap_result_t actual_word;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      actual_word.key       = out_chan.out_key;
      actual_word.payload   = out_chan.out_payload;
      actual_word.status    = status_t'(out_chan.status);
      actual_word.occupancy = out_chan.occupancy;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result word key=%h payload=%h status=%0d occupancy=%0d",
                 $time, out_chan.out_key, out_chan.out_payload, out_chan.status,
                 out_chan.occupancy);
      end else begin
        expected_word = pending_results.pop_front();
        words_checked++;
        if (expected_word.status == ST_FULL) full_hits++;
        if (expected_word.status == ST_EMPTY) empty_hits++;
        if (actual_word !== expected_word) begin
          error_count++;
          $display("%0t: mismatch expected key=%h payload=%h status=%0d occupancy=%0d",
                   $time, expected_word.key, expected_word.payload, expected_word.status,
                   expected_word.occupancy);
          $display("%0t:          actual   key=%h payload=%h status=%0d occupancy=%0d",
                   $time, out_chan.out_key, out_chan.out_payload, out_chan.status,
                   out_chan.occupancy);
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without a word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("** binary_min_heap_queue: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    shadow_count = 0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    full_hits = 0;
    empty_hits = 0;
    peak_occupancy = 0;
    hold_requests = 0;
    set_idling(12, 47);
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.cmd        <= CMD_INSERT;
    in_chan.in_key     <= '0;
    in_chan.in_payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_traffic(180);
    set_idling(47, 12);
    test_fill_and_drain();
    test_random_traffic(180);
    set_idling(0, 0);
    test_result_backpressure();
    test_random_traffic(180);

    // Let the last results drain, then give the block a few more cycles.
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command words and checked %0d results, peak occupancy %0d.",
             words_sent, words_checked, peak_occupancy);
    $display("Inserts on a full heap: %0d, extracts on an empty heap: %0d.",
             full_hits, empty_hits);
    if (error_count == 0) begin
      $display("** binary_min_heap_queue: PASSED **");
    end else begin
      $display("** binary_min_heap_queue: FAILED **");
    end
    $finish;
  end

endmodule
